>>> rtl/htfd_pkg.sv
// shared types, constants and the crc-8 step for the humidity/temperature frame decoder
// no dependencies; imported by every module of the block but htfd_fifo

package htfd_pkg;

	localparam int FQ_DEPTH_DEF = 4;
	localparam int RQ_DEPTH_DEF = 4;

	localparam int APB_AW = 3;
	localparam int APB_DW = 32;
	localparam int LIM_W  = 15;

	localparam logic [7:0] CRC_INIT  = 8'hFF;
	localparam logic [7:0] CRC_POLY  = 8'h31;
	localparam logic [2:0] LAST_BYTE = 3'd6;
	localparam int         BUSY_BIT  = 7;

	localparam logic [1:0] RC_OK    = 2'd0;
	localparam logic [1:0] RC_BUSY  = 2'd1;
	localparam logic [1:0] RC_CRC   = 2'd2;
	localparam logic [1:0] RC_RANGE = 2'd3;

	localparam logic [LIM_W-1:0] TEMP_MIN_RST = 15'h7060; // -4000
	localparam logic [LIM_W-1:0] TEMP_MAX_RST = 15'd8500;

	localparam logic [14:0] TEMP_SCALE = 15'd20000;
	localparam logic [13:0] HUM_SCALE  = 14'd10000;
	localparam logic signed [15:0] TEMP_OFFSET = 16'sd5000;

	// frame record handed from the front to the back
	typedef struct packed {
		logic [7:0]  status;
		logic [19:0] hraw;
		logic [19:0] traw;
		logic        crc_bad;
	} frame_t;

	// one finished result
	typedef struct packed {
		logic [1:0]  code;
		logic [7:0]  status;
		logic [19:0] hraw;
		logic [19:0] traw;
		logic [13:0] hcenti;
		logic [14:0] tcenti;
	} res_t;

	typedef struct packed {
		logic [LIM_W-1:0] tmin;
		logic [LIM_W-1:0] tmax;
	} limits_t;

	// msb-first crc-8 over one byte, eight fixed shift/xor steps
	function automatic logic [7:0] crc_fold(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int i = 0; i < 8; i++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

>>> rtl/humidity_temp_frame_decoder.sv
// top level of the humidity/temperature frame decoder: config registers, front, queues, back
// depends on htfd_pkg, htfd_fifo, htfd_front, htfd_back
//
// channel   direction  handshake                  payload
// -------   ---------  -------------------------  ----------------------------------------
// input     in         push / full                rx_byte, frame_start
// result    out        empty / pop                result_code, sensor_status, humidity_raw,
//                                                 temperature_raw, humidity_centi,
//                                                 temperature_centi
// config    in/out     psel, penable, pwrite,     temp_min_centi at 0x0, temp_max_centi at 0x4
//                      pready (always high)
//
// one byte is taken per cycle while full is low; the crc step is eight fixed xor stages, computed combinationally
// a frame's result shows on the result side after its checksum byte transfer, passing through
//   the frame queue entry, then the multiply stage, then the result queue
// full follows the frame queue alone, so bytes stall only when finished frames back up
// a stalled pop leaves the front free until both queues and the multiply stage fill
// reset clears counters and queue pointers at once; there is no clearing pass

module humidity_temp_frame_decoder #(
	parameter int FQ_DEPTH = htfd_pkg::FQ_DEPTH_DEF,
	parameter int RQ_DEPTH = htfd_pkg::RQ_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// input side
	input  logic                          push,
	output logic                          full,
	input  logic [7:0]                    rx_byte,
	input  logic                          frame_start,
	// result side
	output logic                          empty,
	input  logic                          pop,
	output logic [1:0]                    result_code,
	output logic [7:0]                    sensor_status,
	output logic [19:0]                   humidity_raw,
	output logic [19:0]                   temperature_raw,
	output logic [13:0]                   humidity_centi,
	output logic signed [14:0]            temperature_centi,
	// configuration
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [htfd_pkg::APB_AW-1:0]   paddr,
	input  logic [htfd_pkg::APB_DW-1:0]   pwdata,
	output logic [htfd_pkg::APB_DW-1:0]   prdata,
	output logic                          pready
);

	import htfd_pkg::*;

	// limit registers
	logic [LIM_W-1:0] tmin_q;
	logic [LIM_W-1:0] tmax_q;
	limits_t          lim;
	logic             cfg_wr;

	// front to frame queue
	logic   take;
	logic   rec_push;
	frame_t rec;
	logic   fq_full;
	logic   fq_empty;
	logic   fq_pop;
	frame_t fq_rec;

	// back to result queue
	logic rq_push;
	logic rq_full;
	res_t rq_res;
	res_t head;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	// register index is address bit 2, low bits ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tmin_q <= TEMP_MIN_RST;
			tmax_q <= TEMP_MAX_RST;
		end else if (cfg_wr) begin
			if (paddr[2]) begin
				tmax_q <= pwdata[LIM_W-1:0];
			end else begin
				tmin_q <= pwdata[LIM_W-1:0];
			end
		end
	end

	assign prdata   = paddr[2] ? {{(APB_DW-LIM_W){1'b0}}, tmax_q}
	                           : {{(APB_DW-LIM_W){1'b0}}, tmin_q};
	assign lim.tmin = tmin_q;
	assign lim.tmax = tmax_q;

	// a byte transfer needs room for one more frame record
	assign full = fq_full;
	assign take = push & ~fq_full;

	htfd_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.take        (take),
		.rx_byte     (rx_byte),
		.frame_start (frame_start),
		.rec_push    (rec_push),
		.rec         (rec)
	);

	htfd_fifo #(
		.W     ($bits(frame_t)),
		.DEPTH (FQ_DEPTH)
	) u_frame_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (rec_push),
		.wdata  (rec),
		.full   (fq_full),
		.pop    (fq_pop),
		.rdata  (fq_rec),
		.empty  (fq_empty)
	);

	htfd_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.fq_empty (fq_empty),
		.fq_rec   (fq_rec),
		.fq_pop   (fq_pop),
		.lim      (lim),
		.rq_full  (rq_full),
		.rq_push  (rq_push),
		.rq_res   (rq_res)
	);

	htfd_fifo #(
		.W     ($bits(res_t)),
		.DEPTH (RQ_DEPTH)
	) u_result_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (rq_push),
		.wdata  (rq_res),
		.full   (rq_full),
		.pop    (pop),
		.rdata  (head),
		.empty  (empty)
	);

	// oldest waiting result
	assign result_code       = head.code;
	assign sensor_status     = head.status;
	assign humidity_raw      = head.hraw;
	assign temperature_raw   = head.traw;
	assign humidity_centi    = head.hcenti;
	assign temperature_centi = head.tcenti;

endmodule

>>> rtl/htfd_fifo.sv
// small first-in first-out queue with registered storage and combinational head read
// depends on nothing; used between front and back and on the result side

module htfd_fifo #(
	parameter int W     = 8,
	parameter int DEPTH = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wdata,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] rdata,
	output logic         empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [W-1:0]  mem_q [DEPTH];
	logic [AW-1:0] wptr_q;
	logic [AW-1:0] rptr_q;
	logic [AW:0]   count_q;
	logic          do_push;
	logic          do_pop;

	assign full    = (count_q == (AW+1)'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push & ~full;
	assign do_pop  = pop & ~empty;
	assign rdata   = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= (wptr_q == AW'(DEPTH-1)) ? '0 : wptr_q + 1'b1;
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == AW'(DEPTH-1)) ? '0 : rptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> rtl/htfd_front.sv
// front part: byte counting, crc-8 folding and capture of status and packed raw values
// depends on htfd_pkg

module htfd_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              take,
	input  logic [7:0]        rx_byte,
	input  logic              frame_start,
	output logic              rec_push,
	output htfd_pkg::frame_t  rec
);

	import htfd_pkg::*;

	logic [2:0]  pos_q;
	logic [7:0]  crc_q;
	logic [7:0]  status_q;
	logic [39:0] payload_q;

	// last byte of a frame carries the checksum
	assign rec_push    = take & ~frame_start & (pos_q == LAST_BYTE);
	assign rec.status  = status_q;
	assign rec.hraw    = payload_q[39:20];
	assign rec.traw    = payload_q[19:0];
	assign rec.crc_bad = (crc_q != rx_byte);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			crc_q <= CRC_INIT;
		end else if (take) begin
			if (frame_start) begin
				pos_q <= 3'd1;
				crc_q <= crc_fold(CRC_INIT, rx_byte);
			end else if (pos_q == LAST_BYTE) begin
				pos_q <= '0;
			end else if (pos_q != '0 && pos_q < LAST_BYTE) begin
				pos_q <= pos_q + 1'b1;
				crc_q <= crc_fold(crc_q, rx_byte);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			if (frame_start) begin
				status_q <= rx_byte;
			end else if (pos_q != '0 && pos_q < LAST_BYTE) begin
				payload_q <= {payload_q[31:0], rx_byte};
			end
		end
	end

endmodule

>>> rtl/htfd_back.sv
// back part: fixed-point scaling, busy/checksum/limit checks, result assembly
// depends on htfd_pkg

module htfd_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fq_empty,
	input  htfd_pkg::frame_t  fq_rec,
	output logic              fq_pop,
	input  htfd_pkg::limits_t lim,
	input  logic              rq_full,
	output logic              rq_push,
	output htfd_pkg::res_t    rq_res
);

	import htfd_pkg::*;

	logic        valid_s1;
	frame_t      rec_s1;
	logic [33:0] hprod_s1;
	logic [34:0] tprod_s1;

	logic signed [15:0] t_val;
	logic signed [15:0] t_min;
	logic signed [15:0] t_max;
	logic [1:0]         code;

	// stage one is free or drains this cycle
	assign fq_pop  = ~fq_empty & (~valid_s1 | ~rq_full);
	assign rq_push = valid_s1 & ~rq_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (~valid_s1 | ~rq_full) begin
			valid_s1 <= ~fq_empty;
		end
	end

	always_ff @(posedge clk) begin
		if (fq_pop) begin
			rec_s1   <= fq_rec;
			hprod_s1 <= 34'(fq_rec.hraw) * 34'(HUM_SCALE);
			tprod_s1 <= 35'(fq_rec.traw) * 35'(TEMP_SCALE);
		end
	end

	always_comb begin
		t_val = $signed({1'b0, tprod_s1[34:20]}) - TEMP_OFFSET;
		t_min = $signed({lim.tmin[LIM_W-1], lim.tmin});
		t_max = $signed({lim.tmax[LIM_W-1], lim.tmax});
		if (rec_s1.status[BUSY_BIT]) begin
			code = RC_BUSY;
		end else if (rec_s1.crc_bad) begin
			code = RC_CRC;
		end else if (t_val < t_min || t_val > t_max) begin
			code = RC_RANGE;
		end else begin
			code = RC_OK;
		end
		rq_res.code   = code;
		rq_res.status = rec_s1.status;
		rq_res.hraw   = rec_s1.hraw;
		rq_res.traw   = rec_s1.traw;
		rq_res.hcenti = (code == RC_OK) ? hprod_s1[33:20] : '0;
		rq_res.tcenti = (code == RC_OK) ? t_val[14:0] : '0;
	end

endmodule

>>> rtl/htfd_checker.sv
// port-level checks on the result side of the frame decoder, bound to the top level
// depends on htfd_pkg and humidity_temp_frame_decoder

module htfd_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               empty,
	input  logic               pop,
	input  logic [1:0]         result_code,
	input  logic [7:0]         sensor_status,
	input  logic [13:0]        humidity_centi,
	input  logic signed [14:0] temperature_centi
);

	import htfd_pkg::*;

	// scaled values only on a clean frame
	a_zero_unless_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result_code != RC_OK) |-> (humidity_centi == '0 && temperature_centi == '0))
		else $error("scaled values nonzero on a failed frame");

	// busy code exactly when the status busy bit is set
	a_busy_code: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> ((result_code == RC_BUSY) == sensor_status[BUSY_BIT]))
		else $error("busy code does not match status bit");

	// a clean frame stays within the scaled ranges
	a_ok_range: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result_code == RC_OK) |->
		(humidity_centi <= 14'd9999 && temperature_centi >= -15'sd5000))
		else $error("scaled value out of range");

	// a waiting result holds until its transfer
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(result_code) && $stable(sensor_status)))
		else $error("waiting result changed without a transfer");

endmodule

bind humidity_temp_frame_decoder htfd_checker u_htfd_checker (.*);
